// ----- src/sso_pkg.sv -----
// ----------------------------------------------------------------------------
// sso_pkg: shared types and constants of the servo sine oscillator
// Sizes, command codes, register indexes and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package sso_pkg;

  localparam int SINE_ADDR_BITS  = 10;
  localparam int PHASE_FRAC_BITS = 16;

  localparam int QUARTER_BITS = SINE_ADDR_BITS - 2;
  localparam int QUARTER_LEN  = 1 << QUARTER_BITS;
  localparam int U_SHIFT      = 18 - SINE_ADDR_BITS;

  localparam int CENTER_DEG = 90;
  localparam int ANGLE_MAX  = 180;

  // Coefficients of sin(pi/2 * u), Q30.
  localparam logic [63:0] SIN_C1 = 64'd1686629713;
  localparam logic [63:0] SIN_C3 = 64'd693598669;
  localparam logic [63:0] SIN_C5 = 64'd85569306;
  localparam logic [63:0] SIN_C7 = 64'd5026995;
  localparam logic [63:0] SIN_C9 = 64'd172272;

  typedef logic [14:0] sine_mag_t;
  typedef sine_mag_t sine_table_t [QUARTER_LEN+1];

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_RESTART = 3'd1,
    OP_MANUAL  = 3'd2,
    OP_ATTACH  = 3'd3,
    OP_DETACH  = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    CFG_AMPLITUDE       = 3'd0,
    CFG_CENTER_OFFSET   = 3'd1,
    CFG_PHASE_OFFSET    = 3'd2,
    CFG_TRIM            = 3'd3,
    CFG_REVERSE         = 3'd4,
    CFG_STOP_LIMIT      = 3'd5,
    CFG_PHASE_STEP      = 3'd6,
    CFG_UPDATE_INTERVAL = 3'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_OSC    = 2'd1,
    KIND_MANUAL = 2'd2
  } kind_t;

  // One accepted beat after its state update, waiting for the angle stage.
  typedef struct packed {
    kind_t                      kind;
    logic                       status;
    logic [PHASE_FRAC_BITS-1:0] phase;
    logic signed [8:0]          manual_sum;
  } item_t;

  typedef struct packed {
    logic [7:0]        amplitude;
    logic signed [7:0] center_offset;
    logic signed [7:0] trim;
    logic              reverse;
  } angle_cfg_t;

  // Quarter-wave polynomial, u in Q16 (u = 65536 is a quarter turn), result Q15.
  function automatic sine_mag_t quarter_sine(input logic [16:0] u);
    logic [63:0] u64;
    logic [63:0] u2;
    logic [63:0] t;
    logic [63:0] r;
    u64 = 64'(u);
    u2  = (u64 * u64) >> 16;
    t   = SIN_C9;
    t   = SIN_C7 - ((t * u2) >> 16);
    t   = SIN_C5 - ((t * u2) >> 16);
    t   = SIN_C3 - ((t * u2) >> 16);
    t   = SIN_C1 - ((t * u2) >> 16);
    r   = (t * u64) >> 16;
    r   = (r + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[14:0];
  endfunction

  function automatic sine_table_t build_sine_table();
    sine_table_t tbl;
    for (int j = 0; j <= QUARTER_LEN; j++) begin
      tbl[j] = quarter_sine(17'(j << U_SHIFT));
    end
    return tbl;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

// ----- src/sso_angle.sv -----
// ----------------------------------------------------------------------------
// sso_angle: angle datapath
// Sine lookup, amplitude scaling, centering, reversal, trim and saturation.
// ----------------------------------------------------------------------------
module sso_angle
  import sso_pkg::*;
(
  input  item_t      item,
  input  angle_cfg_t cfg,
  output logic [7:0] angle
);

  logic [PHASE_FRAC_BITS+SINE_ADDR_BITS-1:0] phase_wide;
  logic [SINE_ADDR_BITS-1:0] idx;
  logic [1:0]                quad;
  logic [QUARTER_BITS-1:0]   quarter_pos;
  logic [QUARTER_BITS:0]     tbl_idx;
  sine_mag_t                 mag;
  logic [22:0]               prod;
  logic [22:0]               prod_rnd;
  logic [7:0]                deg;
  logic signed [11:0]        osc_deg;
  logic signed [11:0]        base;
  logic signed [11:0]        pre_osc;
  logic signed [11:0]        pre_man;
  logic signed [11:0]        total;

  always_comb begin
    // Appending zeros makes the top bits the table address whether the
    // phase is wider or narrower than the address.
    phase_wide  = {item.phase, {SINE_ADDR_BITS{1'b0}}};
    idx         = phase_wide[PHASE_FRAC_BITS+SINE_ADDR_BITS-1 -: SINE_ADDR_BITS];
    quad        = idx[SINE_ADDR_BITS-1 -: 2];
    quarter_pos = idx[QUARTER_BITS-1:0];
    tbl_idx     = quad[0] ? ((QUARTER_BITS+1)'(QUARTER_LEN) - {1'b0, quarter_pos})
                          : {1'b0, quarter_pos};
    mag         = SINE_TABLE[tbl_idx];

    // Rounding on the magnitude gives half away from zero.
    prod     = 23'(cfg.amplitude) * 23'(mag);
    prod_rnd = prod + 23'd16384;
    deg      = prod_rnd[22:15];
    osc_deg  = quad[1] ? -$signed({4'b0000, deg}) : $signed({4'b0000, deg});

    base = osc_deg + {{4{cfg.center_offset[7]}}, cfg.center_offset};
    if (cfg.reverse) begin
      base = -base;
    end
    pre_osc = base + {{4{cfg.trim[7]}}, cfg.trim};

    pre_man = {{3{item.manual_sum[8]}}, item.manual_sum};
    if (cfg.reverse) begin
      pre_man = -pre_man;
    end

    total = ((item.kind == KIND_OSC) ? pre_osc : pre_man) + 12'(CENTER_DEG);

    if (item.kind == KIND_NONE) begin
      angle = 8'd0;
    end else if (total < 12'sd0) begin
      angle = 8'd0;
    end else if (total > 12'(ANGLE_MAX)) begin
      angle = 8'(ANGLE_MAX);
    end else begin
      angle = total[7:0];
    end
  end

endmodule

// ----- src/servo_sine_oscillator.sv -----
// ----------------------------------------------------------------------------
// servo_sine_oscillator: sine oscillator for a hobby servo
// Tick counting, phase accumulation, commands and servo angle generation.
// ----------------------------------------------------------------------------
// Every input beat (a millisecond tick or a command) yields exactly one result
// beat. The block takes one beat per clock cycle unless the result register is
// stalled. The input stage updates the tick count, phase accumulator and
// attach state and registers the beat; the result stage looks up the
// quarter-wave sine table, scales it by the amplitude in one 8 by 15 bit
// multiply, centers, trims and saturates the angle into the result register.
// That single pass from table to result sets the rate of one beat per cycle
// while the output is not stalled. A stalled result register holds one result
// while one more beat waits in the input register.
module servo_sine_oscillator
  import sso_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] manual_angle, [8] apply_trim, zero fill
  input  logic [2:0]  s_tuser,   // [2:0] opcode

  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] servo_angle
  output logic [1:0]  m_tuser,   // [0] write_valid, [1] status

  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [7:0]        amplitude;
  logic signed [7:0] center_offset;
  logic [15:0]       phase_offset;
  logic signed [7:0] trim;
  logic              reverse;
  logic [31:0]       stop_limit;
  logic [15:0]       phase_step;
  logic [7:0]        update_interval;

  logic [31:0] phase_acc;
  logic [31:0] phase_acc_next;
  logic [8:0]  tick_count;
  logic [8:0]  tick_count_next;
  logic        halted;
  logic        halted_next;
  logic        enabled_flag;
  logic        enabled_flag_next;
  logic [31:0] stop_limit_next;

  logic        s1_valid;
  item_t       s1_item;
  item_t       item_next;

  logic        accept;
  logic        out_adv;
  logic [31:0] osc_phase;
  logic [31:0] phase_stepped;
  logic [8:0]  tick_inc;
  logic signed [8:0] manual_sum;
  logic [7:0]  angle;
  angle_cfg_t  angle_cfg;

  assign out_adv  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || out_adv;
  assign accept   = s_tvalid && s_tready;

  assign osc_phase     = phase_acc + 32'(phase_offset);
  assign phase_stepped = phase_acc + 32'(phase_step);
  assign tick_inc      = tick_count + 9'd1;
  assign manual_sum    = {s_tdata[7], s_tdata[7:0]} +
                         (s_tdata[8] ? {trim[7], trim} : 9'sd0);

  always_comb begin
    phase_acc_next    = phase_acc;
    tick_count_next   = tick_count;
    halted_next       = halted;
    enabled_flag_next = enabled_flag;
    stop_limit_next   = stop_limit;
    item_next.kind       = KIND_NONE;
    item_next.status     = 1'b0;
    item_next.phase      = osc_phase[PHASE_FRAC_BITS-1:0];
    item_next.manual_sum = manual_sum;

    if (accept) begin
      case (opcode_t'(s_tuser))
        OP_TICK: begin
          if (!enabled_flag) begin
            item_next.status = 1'b1;
          end else if (tick_inc > {1'b0, update_interval}) begin
            tick_count_next = 9'd0;
            if (!halted) begin
              item_next.kind = KIND_OSC;
            end
            phase_acc_next = phase_stepped;
            if (stop_limit != 32'd0 && phase_stepped > stop_limit) begin
              halted_next     = 1'b1;
              stop_limit_next = 32'd0;
            end
          end else begin
            tick_count_next = tick_inc;
          end
        end
        OP_RESTART: begin
          phase_acc_next  = 32'd0;
          item_next.phase = PHASE_FRAC_BITS'(32'(phase_offset));
          if (!enabled_flag) begin
            item_next.status = 1'b1;
          end else begin
            item_next.kind = KIND_OSC;
          end
        end
        OP_MANUAL: begin
          if (!enabled_flag) begin
            item_next.status = 1'b1;
          end else begin
            item_next.kind = KIND_MANUAL;
          end
        end
        OP_ATTACH: begin
          if (enabled_flag) begin
            item_next.status = 1'b1;
          end else begin
            phase_acc_next    = 32'd0;
            enabled_flag_next = 1'b1;
          end
        end
        OP_DETACH: begin
          if (!enabled_flag) begin
            item_next.status = 1'b1;
          end else begin
            phase_acc_next    = 32'd0;
            enabled_flag_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude       <= 8'd45;
      center_offset   <= 8'sd0;
      phase_offset    <= 16'd0;
      trim            <= 8'sd0;
      reverse         <= 1'b0;
      stop_limit      <= 32'd0;
      phase_step      <= 16'd655;
      update_interval <= 8'd20;
      phase_acc       <= 32'd0;
      tick_count      <= 9'd0;
      halted          <= 1'b0;
      enabled_flag    <= 1'b0;
    end else begin
      phase_acc    <= phase_acc_next;
      tick_count   <= tick_count_next;
      halted       <= halted_next;
      enabled_flag <= enabled_flag_next;
      // A register write takes priority over the clear on halt.
      if (!(cfg_we && cfg_index_t'(cfg_index) == CFG_STOP_LIMIT)) begin
        stop_limit <= stop_limit_next;
      end
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_AMPLITUDE:       amplitude       <= cfg_wdata[7:0];
          CFG_CENTER_OFFSET:   center_offset   <= cfg_wdata[7:0];
          CFG_PHASE_OFFSET:    phase_offset    <= cfg_wdata[15:0];
          CFG_TRIM:            trim            <= cfg_wdata[7:0];
          CFG_REVERSE:         reverse         <= cfg_wdata[0];
          CFG_STOP_LIMIT:      stop_limit      <= cfg_wdata;
          CFG_PHASE_STEP:      phase_step      <= cfg_wdata[15:0];
          CFG_UPDATE_INTERVAL: update_interval <= cfg_wdata[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign angle_cfg.amplitude     = amplitude;
  assign angle_cfg.center_offset = center_offset;
  assign angle_cfg.trim          = trim;
  assign angle_cfg.reverse       = reverse;

  sso_angle u_angle (
    .item  (s1_item),
    .cfg   (angle_cfg),
    .angle (angle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (out_adv) begin
        m_tvalid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      s1_item <= item_next;
    end
    if (out_adv) begin
      m_tdata <= angle;
      m_tuser <= {s1_item.status, s1_item.kind != KIND_NONE};
    end
  end

endmodule
